### rtl/gamma_ramp_generator_defines.svh
// Assertion macros for the gamma ramp generator checker
`ifndef GAMMA_RAMP_GENERATOR_DEFINES_SVH
`define GAMMA_RAMP_GENERATOR_DEFINES_SVH
// Implication checked every clock outside reset.
`define GRG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gamma ramp check failed");
// Implication whose consequent is checked in the next cycle.
`define GRG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gamma ramp check failed");
`endif

### rtl/grg_pkg.sv
// Package: constants, cell types and tables of the gamma ramp generator
package grg_pkg;
   localparam int LVL_W   = 8;
   localparam int GAM_W   = 6;
   localparam int LOG_FB  = 20;
   localparam int LOG_W   = 24;
   localparam int EXP_W   = 22;
   localparam int MANT_W  = 32;
   localparam int ACC_W   = 31;
   localparam logic [GAM_W-1:0] GAMMA_RESET = 6'd10;
   localparam logic [LOG_W-1:0] LOG_EIGHT = 24'h080000;

   // floor(sqrt(v)), bit-pair method; used at elaboration only
   function automatic logic [63:0] isqrt_c(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 64'd0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(-2^(k-16)) in Q30, index k = 0..15: floor square roots chained from 2^-0.5
   function automatic logic [ACC_W-1:0] exp_root(input logic [3:0] k);
      logic [63:0] r;
      r = isqrt_c(64'd1 << 59);
      for (int j = 15; j > int'(k); j--) begin
         r = isqrt_c(r << 30);
      end
      return r[ACC_W-1:0];
   endfunction

   typedef struct packed {
      logic              vld;
      logic [LVL_W-1:0]  level;
      logic [GAM_W-1:0]  gam;
      logic [3:0]        pos;
      logic [MANT_W-1:0] mant;
      logic [LOG_FB-1:0] frac;
   } log_cell_type;

   typedef struct packed {
      logic              vld;
      logic [LVL_W-1:0]  level;
      logic [EXP_W-1:0]  e;
      logic [ACC_W-1:0]  acc;
   } exp_cell_type;
endpackage

### rtl/grg_if.sv
// Valid/ready channel interface carrying a payload
interface grg_if #(parameter int DW = 8);
   logic          valid;
   logic          ready;
   logic [DW-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/gamma_ramp_generator.sv
// Top level of the gamma ramp generator: log chain, scale stage, exp chain
// Usage:
//  - req channel carries one 8-bit level per item; rsp channel returns
//    level_echo and the 16-bit ramp_value for that level, in order.
//  - csr_we/csr_wdata write gamma in tenths (reset 10); write only while idle.
// Pipeline:
//  - 20 log cells (one squaring each), a rounding/scale stage, a divide-by-ten
//    stage, 16 exp cells (one square-root constant each), and the output
//    register fed by the final scale logic: 39 register stages in all.
// Throughput: one item per clock unless rsp stalls (single-item-per-cell chain).
// Stall: the whole chain advances only when the output register is empty or
//  being taken; req_ready follows that, so nothing is lost when rsp stalls.
// Reset: synchronous, clears all valid bits and sets gamma to 1.0.
module gamma_ramp_generator #(
   parameter int OUT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   grg_if.sink                 req,
   grg_if.source               rsp,
   input  logic                csr_we,
   input  logic [5:0]          csr_wdata
);
   localparam int NLOG = grg_pkg::LOG_FB;
   localparam int NEXP = 16;

   logic [grg_pkg::GAM_W-1:0] gamma_ff;
   logic advance;
   logic out_vld_ff;
   logic [7:0] out_lvl_ff;
   logic [OUT_BITS-1:0] out_val_ff;

   grg_pkg::log_cell_type lc [NLOG+1];
   grg_pkg::exp_cell_type ec_head;

   assign advance = !out_vld_ff || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= grg_pkg::GAMMA_RESET;
      end else if (csr_we) begin
         gamma_ff <= csr_wdata;
      end
   end

   // Entry: normalize level+1 to a Q1.30 mantissa with exponent pos
   logic [8:0] x;
   logic [3:0] p;
   always_comb begin
      x = {1'b0, req.data} + 9'd1;
      p = 4'd0;
      for (int i = 1; i <= 8; i++) begin
         if (x[i]) p = 4'(i);
      end
      lc[0].vld   = req.valid;
      lc[0].level = req.data;
      lc[0].gam   = gamma_ff;
      lc[0].pos   = p;
      lc[0].mant  = 32'({x, 30'd0} >> p);
      lc[0].frac  = '0;
   end

   for (genvar i = 0; i < NLOG; i++) begin : g_log
      grg_log_cell u_cell (.clock, .reset, .advance, .prev(lc[i]), .next(lc[i+1]));
   end

   // Scale stage 1: round log, distance below eight, times gamma, plus 5
   logic s1_vld_ff;
   logic [7:0] s1_lvl_ff;
   logic [29:0] s1_prod_ff;
   logic [grg_pkg::LOG_W-1:0] lq, nl;
   always_comb begin
      lq = {4'd0, lc[NLOG].pos, 16'd0} + (({4'd0, lc[NLOG].frac} + 24'd8) >> 4);
      nl = (lq >= grg_pkg::LOG_EIGHT) ? '0 : grg_pkg::LOG_EIGHT - lq;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= lc[NLOG].vld;
      end
      if (advance) begin
         s1_lvl_ff  <= lc[NLOG].level;
         s1_prod_ff <= ({10'd0, nl[19:0]} * {24'd0, lc[NLOG].gam}) + 30'd5;
      end
   end

   // Scale stage 2: divide by ten via reciprocal multiply
   logic [63:0] recip;
   assign recip = {34'd0, s1_prod_ff} * 64'd3435973837;
   always_comb begin
      ec_head.vld   = s1_vld_ff;
      ec_head.level = s1_lvl_ff;
      ec_head.e     = 22'(recip >> 35);
      ec_head.acc   = 31'd1073741824;
   end
   grg_pkg::exp_cell_type e0_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         e0_ff.vld <= 1'b0;
      end else if (advance) begin
         e0_ff <= ec_head;
      end
   end

   grg_pkg::exp_cell_type ex [NEXP+1];
   assign ex[0] = e0_ff;
   for (genvar k = 0; k < NEXP; k++) begin : g_exp
      grg_exp_cell #(.BIT(NEXP-1-k)) u_cell (
         .clock, .reset, .advance, .prev(ex[k]), .next(ex[k+1]));
   end

   // Final stage: times full scale, shift by 30+ei with rounding, saturate
   logic [5:0] ei;
   logic [47:0] t;
   logic [71:0] v;
   logic [OUT_BITS-1:0] res;
   localparam logic [47:0] FULL = 48'((64'd1 << OUT_BITS) - 64'd1);
   always_comb begin
      ei  = ex[NEXP].e[21:16];
      t   = {17'd0, ex[NEXP].acc} * FULL;
      v   = ({24'd0, t} + (72'd1 << (6'd29 + ei))) >> (6'd30 + ei);
      if (ei >= 6'd24) res = '0;
      else if (v > 72'(FULL)) res = FULL[OUT_BITS-1:0];
      else res = v[OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= ex[NEXP].vld;
      end
      if (advance) begin
         out_lvl_ff <= ex[NEXP].level;
         out_val_ff <= res;
      end
   end

   assign rsp.valid = out_vld_ff;
   // ramp_value field is 16 bits wide whatever OUT_BITS is
   assign rsp.data  = {out_lvl_ff, 16'(out_val_ff)};
endmodule

### rtl/grg_log_cell.sv
// Log cell: one squaring step of log2 mantissa per stage
module grg_log_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  grg_pkg::log_cell_type prev,
   output grg_pkg::log_cell_type next
);
   grg_pkg::log_cell_type next_ff, next_in;
   logic [63:0] sq;

   always_comb begin
      sq = {32'd0, prev.mant} * {32'd0, prev.mant};
      next_in = prev;
      next_in.mant = sq[61:30];
      next_in.frac = {prev.frac[grg_pkg::LOG_FB-2:0], 1'b0};
      if (sq[61]) begin
         next_in.frac[0] = 1'b1;
         next_in.mant = sq[62:31];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff.vld <= 1'b0;
      end else if (advance) begin
         next_ff <= next_in;
      end
   end
   assign next = next_ff;
endmodule

### rtl/grg_exp_cell.sv
// Exp cell: multiplies in one square-root constant per stage
module grg_exp_cell #(
   parameter int BIT = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  grg_pkg::exp_cell_type prev,
   output grg_pkg::exp_cell_type next
);
   localparam logic [grg_pkg::ACC_W-1:0] ROOT = grg_pkg::exp_root(4'(BIT));

   grg_pkg::exp_cell_type next_ff, next_in;
   logic [61:0] prod;

   always_comb begin
      prod = {31'd0, prev.acc} * {31'd0, ROOT};
      next_in = prev;
      if (prev.e[BIT]) begin
         next_in.acc = prod[60:30];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff.vld <= 1'b0;
      end else if (advance) begin
         next_ff <= next_in;
      end
   end
   assign next = next_ff;
endmodule

### rtl/grg_checker.sv
// Port checker for the gamma ramp generator, bound to the top level
`include "gamma_ramp_generator_defines.svh"
module grg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_data
);
   `GRG_ASSERT_IMP(a_ready_follows, clock, reset, !rsp_valid, req_ready)
   `GRG_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `GRG_ASSERT_IMP(a_top_full, clock, reset, rsp_valid && rsp_data[23:16] == 8'hFF, rsp_data[15:0] == 16'hFFFF)
   `GRG_ASSERT_IMP(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready)
endmodule

bind gamma_ramp_generator grg_checker u_grg_checker (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));
